// File: sv/bfds_pkg.sv
// Shared types and constants of the box filter downscaler.
// No dependencies; every other file of the block but bfds_ram uses this package.
package bfds_pkg;

    localparam int PIX_W      = 8;
    localparam int FACTOR_W   = 5;
    localparam int SIZE_W     = 9;
    localparam int ROW_W      = 8;
    localparam int HEIGHT_LIM = 256;
    localparam int ADDR_W     = 4;
    localparam int REG_IDX_W  = 2;
    localparam int DATA_W     = 32;
    localparam int NUM_CH     = 4;

    localparam logic [REG_IDX_W-1:0] REG_FACTOR = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef logic [PIX_W-1:0] t_chan;

    typedef struct packed {
        logic accept;
        logic phase_first;
        logic phase_last;
        logic row_first;
        logic emit;
        logic frame_end;
        logic recip_start;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_room;
        logic recip_busy;
    } t_dp_status;

endpackage

// File: sv/bfds_if.sv
// Stream interfaces of the box filter downscaler: source pixels and averaged results.
// Depends on bfds_pkg for the channel type.
interface bfds_pix_if;
    logic                 valid;
    logic                 ready;
    bfds_pkg::t_chan      in_red;
    bfds_pkg::t_chan      in_green;
    bfds_pkg::t_chan      in_blue;
    bfds_pkg::t_chan      in_alpha;

    modport source (output valid, output in_red, output in_green, output in_blue,
                    output in_alpha, input ready);
    modport sink   (input valid, input in_red, input in_green, input in_blue,
                    input in_alpha, output ready);
endinterface

interface bfds_res_if;
    logic                 valid;
    logic                 ready;
    bfds_pkg::t_chan      avg_red;
    bfds_pkg::t_chan      avg_green;
    bfds_pkg::t_chan      avg_blue;
    bfds_pkg::t_chan      avg_alpha;
    logic                 frame_end;

    modport source (output valid, output avg_red, output avg_green, output avg_blue,
                    output avg_alpha, output frame_end, input ready);
    modport sink   (input valid, input avg_red, input avg_green, input avg_blue,
                    input avg_alpha, input frame_end, output ready);
endinterface

// File: sv/bfds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// File: sv/bfds_recip.sv
// Bit-serial reciprocal unit: finds ceil(2^K / factor^2) one quotient bit per cycle.
// Depends on bfds_pkg.
module bfds_recip #(
    parameter int MAX_FACTOR = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [$clog2(MAX_FACTOR+1)-1:0]        i_factor,
    output logic [8 + 4*$clog2(MAX_FACTOR)-1:0]    o_mult,
    output logic                                   o_busy
);
    import bfds_pkg::*;

    localparam int FW   = $clog2(MAX_FACTOR + 1);
    localparam int AL   = 2 * $clog2(MAX_FACTOR);
    localparam int AW   = AL + 1;
    localparam int K    = PIX_W + 2 * AL;
    localparam int CNTW = $clog2(K + 1);

    logic [2*FW-1:0] area_full;
    logic [AW-1:0]   area;
    logic [AW-1:0]   trial;
    logic            take;
    logic [AW-1:0]   r_rem,  n_rem;
    logic [K-1:0]    r_quot, n_quot;
    logic [AW-1:0]   r_div;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic [K-1:0]    r_mult;

    assign area_full = i_factor * i_factor;
    assign area      = AW'(area_full);

    // The dividend is all ones, so every step shifts a one into the remainder.
    assign trial  = {r_rem[AW-2:0], 1'b1};
    assign take   = (trial >= r_div);
    assign n_rem  = take ? (trial - r_div) : trial;
    assign n_quot = {r_quot[K-2:0], take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTW'(K);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNTW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= '0;
            r_div  <= area;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
            if (r_cnt == CNTW'(1)) begin
                r_mult <= n_quot + 1'b1;
            end
        end
    end

    assign o_mult = r_mult;
    assign o_busy = r_busy;
endmodule

// File: sv/bfds_ctrl.sv
// Controller: configuration registers, block and frame position counters,
// and the start-up sequence that waits for the reciprocal. Depends on bfds_pkg.
module bfds_ctrl #(
    parameter int MAX_DST_WIDTH = 256,
    parameter int MAX_FACTOR    = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_psel,
    input  logic                                         i_penable,
    input  logic                                         i_pwrite,
    input  logic [bfds_pkg::ADDR_W-1:0]                  i_paddr,
    input  logic [bfds_pkg::DATA_W-1:0]                  i_pwdata,
    output logic [bfds_pkg::DATA_W-1:0]                  o_prdata,
    input  logic                                         i_in_valid,
    output logic                                         o_in_ready,
    input  bfds_pkg::t_dp_status                         i_status,
    output bfds_pkg::t_dp_cmd                            o_cmd,
    output logic [(MAX_DST_WIDTH > 1 ? $clog2(MAX_DST_WIDTH) : 1)-1:0] o_col,
    output logic [$clog2(MAX_FACTOR+1)-1:0]              o_factor
);
    import bfds_pkg::*;

    localparam int CW = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam int PW = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int FW = $clog2(MAX_FACTOR + 1);

    typedef enum logic [2:0] {
        ST_START = 3'b001,
        ST_WAIT  = 3'b010,
        ST_RUN   = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [FACTOR_W-1:0]   r_factor, n_factor;
    logic [SIZE_W-1:0]     r_width,  n_width;
    logic [SIZE_W-1:0]     r_height, n_height;
    logic [CW-1:0]         r_col,    n_col;
    logic [PW-1:0]         r_cphase, n_cphase;
    logic [PW-1:0]         r_rphase, n_rphase;
    logic [ROW_W-1:0]      r_row,    n_row;

    logic [FW-1:0]         f_eff;
    logic [PW-1:0]         f_last;
    logic [CW-1:0]         w_last;
    logic [ROW_W-1:0]      h_last;
    logic                  accept;
    logic                  cfg_wr;
    logic                  cfg_hit;
    logic [REG_IDX_W-1:0]  cfg_idx;

    // Out-of-range register values act as the nearest legal value.
    always_comb begin
        if (r_factor < FACTOR_W'(2)) begin
            f_eff = FW'(2);
        end else if (32'(r_factor) > MAX_FACTOR) begin
            f_eff = FW'(MAX_FACTOR);
        end else begin
            f_eff = FW'(r_factor);
        end
        f_last = PW'(32'(f_eff) - 1);

        if (r_width == '0) begin
            w_last = '0;
        end else if (32'(r_width) > MAX_DST_WIDTH) begin
            w_last = CW'(MAX_DST_WIDTH - 1);
        end else begin
            w_last = CW'(r_width - 1'b1);
        end

        if (r_height == '0) begin
            h_last = '0;
        end else if (32'(r_height) > HEIGHT_LIM) begin
            h_last = ROW_W'(HEIGHT_LIM - 1);
        end else begin
            h_last = ROW_W'(r_height - 1'b1);
        end
    end

    assign o_in_ready = (r_state == ST_RUN) && i_status.pipe_room;
    assign accept     = i_in_valid && o_in_ready;
    assign cfg_wr     = i_psel && i_penable && i_pwrite;
    assign cfg_idx    = i_paddr[ADDR_W-1:ADDR_W-REG_IDX_W];

    always_comb begin
        o_cmd.accept      = accept;
        o_cmd.phase_first = (r_cphase == '0);
        o_cmd.phase_last  = (r_cphase == f_last);
        o_cmd.row_first   = (r_rphase == '0);
        o_cmd.emit        = (r_cphase == f_last) && (r_rphase == f_last);
        o_cmd.frame_end   = o_cmd.emit && (r_row == h_last) && (r_col == w_last);
        o_cmd.recip_start = (r_state == ST_START);
    end

    assign o_col    = r_col;
    assign o_factor = f_eff;

    always_comb begin
        case (cfg_idx)
            REG_FACTOR: o_prdata = DATA_W'(r_factor);
            REG_WIDTH:  o_prdata = DATA_W'(r_width);
            REG_HEIGHT: o_prdata = DATA_W'(r_height);
            default:    o_prdata = '0;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_factor = r_factor;
        n_width  = r_width;
        n_height = r_height;
        n_col    = r_col;
        n_cphase = r_cphase;
        n_rphase = r_rphase;
        n_row    = r_row;
        cfg_hit  = 1'b0;

        case (r_state)
            ST_START: n_state = ST_WAIT;
            ST_WAIT: begin
                if (!i_status.recip_busy) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_START;
        endcase

        if (accept) begin
            if (r_cphase == f_last) begin
                n_cphase = '0;
                if (r_col == w_last) begin
                    n_col = '0;
                    if (r_rphase == f_last) begin
                        n_rphase = '0;
                        n_row    = (r_row == h_last) ? '0 : r_row + 1'b1;
                    end else begin
                        n_rphase = r_rphase + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end else begin
                n_cphase = r_cphase + 1'b1;
            end
        end

        if (cfg_wr) begin
            case (cfg_idx)
                REG_FACTOR: begin
                    n_factor = i_pwdata[FACTOR_W-1:0];
                    cfg_hit  = 1'b1;
                end
                REG_WIDTH: begin
                    n_width = i_pwdata[SIZE_W-1:0];
                    cfg_hit = 1'b1;
                end
                REG_HEIGHT: begin
                    n_height = i_pwdata[SIZE_W-1:0];
                    cfg_hit  = 1'b1;
                end
                default: cfg_hit = 1'b0;
            endcase
        end

        // A register write restarts the frame and recomputes the reciprocal.
        if (cfg_hit) begin
            n_col    = '0;
            n_cphase = '0;
            n_rphase = '0;
            n_row    = '0;
            n_state  = ST_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_START;
            r_factor <= FACTOR_W'(2);
            r_width  <= SIZE_W'(128);
            r_height <= SIZE_W'(128);
            r_col    <= '0;
            r_cphase <= '0;
            r_rphase <= '0;
            r_row    <= '0;
        end else begin
            r_state  <= n_state;
            r_factor <= n_factor;
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_cphase <= n_cphase;
            r_rphase <= n_rphase;
            r_row    <= n_row;
        end
    end
endmodule

// File: sv/bfds_datapath.sv
// Datapath: horizontal block accumulators, column sum memory, and the
// multiply-by-reciprocal output pipeline. Depends on bfds_pkg, bfds_ram, bfds_recip.
module bfds_datapath #(
    parameter int MAX_DST_WIDTH = 256,
    parameter int MAX_FACTOR    = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  bfds_pkg::t_dp_cmd                            i_cmd,
    input  logic [(MAX_DST_WIDTH > 1 ? $clog2(MAX_DST_WIDTH) : 1)-1:0] i_col,
    input  logic [$clog2(MAX_FACTOR+1)-1:0]              i_factor,
    input  bfds_pkg::t_chan                              i_pix [bfds_pkg::NUM_CH],
    output bfds_pkg::t_dp_status                         o_status,
    output logic                                         o_valid,
    input  logic                                         i_ready,
    output bfds_pkg::t_chan                              o_avg [bfds_pkg::NUM_CH],
    output logic                                         o_frame_end
);
    import bfds_pkg::*;

    localparam int CW  = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam int AL  = 2 * $clog2(MAX_FACTOR);
    localparam int SW  = PIX_W + AL;
    localparam int K   = PIX_W + 2 * AL;
    localparam int PRW = SW + K;

    logic [SW-1:0]        r_hacc  [NUM_CH];
    logic [SW-1:0]        rd_sum  [NUM_CH];
    logic [SW-1:0]        total   [NUM_CH];
    logic [NUM_CH*SW-1:0] ram_rd;
    logic [NUM_CH*SW-1:0] ram_wr;
    logic [K-1:0]         mult;
    logic                 recip_busy;

    logic [SW-1:0]        r_s1_sum  [NUM_CH];
    logic [PRW-1:0]       r_s2_prod [NUM_CH];
    logic [PIX_W-1:0]     r_s3_avg  [NUM_CH];
    logic                 r_s1_v, r_s2_v, r_s3_v;
    logic                 r_s1_fe, r_s2_fe, r_s3_fe;
    logic                 s3_free, s2_move, s2_free, s1_move, s1_load;

    bfds_ram #(
        .WIDTH (NUM_CH * SW),
        .DEPTH (MAX_DST_WIDTH)
    ) u_col_sums (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.accept && i_cmd.phase_last),
        .i_wr_addr (i_col),
        .i_wr_data (ram_wr),
        .i_rd_en   (i_cmd.accept && i_cmd.phase_first),
        .i_rd_addr (i_col),
        .o_rd_data (ram_rd)
    );

    bfds_recip #(
        .MAX_FACTOR (MAX_FACTOR)
    ) u_recip (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.recip_start),
        .i_factor (i_factor),
        .o_mult   (mult),
        .o_busy   (recip_busy)
    );

    // The column sum is read at the first pixel of a block row and is ready
    // by its last pixel, where the row's horizontal sum is folded in.
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            rd_sum[ch] = ram_rd[ch*SW +: SW];
            total[ch]  = (i_cmd.row_first ? '0 : rd_sum[ch]) + r_hacc[ch]
                         + SW'(i_pix[ch]);
            ram_wr[ch*SW +: SW] = total[ch];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !i_cmd.phase_last) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_hacc[ch] <= i_cmd.phase_first ? SW'(i_pix[ch])
                                                : r_hacc[ch] + SW'(i_pix[ch]);
            end
        end
    end

    assign s3_free = !r_s3_v || i_ready;
    assign s2_move = r_s2_v && s3_free;
    assign s2_free = !r_s2_v || s3_free;
    assign s1_move = r_s1_v && s2_free;
    assign s1_load = i_cmd.accept && i_cmd.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= s1_load ? 1'b1 : (s1_move ? 1'b0 : r_s1_v);
            r_s2_v <= s1_move ? 1'b1 : (s2_move ? 1'b0 : r_s2_v);
            r_s3_v <= s2_move ? 1'b1 : (i_ready ? 1'b0 : r_s3_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_sum <= total;
            r_s1_fe  <= i_cmd.frame_end;
        end
        if (s1_move) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_s2_prod[ch] <= PRW'(r_s1_sum[ch]) * PRW'(mult);
            end
            r_s2_fe <= r_s1_fe;
        end
        if (s2_move) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_s3_avg[ch] <= r_s2_prod[ch][K +: PIX_W];
            end
            r_s3_fe <= r_s2_fe;
        end
    end

    // Room is judged from the stage valid bits alone, so the input side never
    // depends combinationally on the output ready.
    assign o_status.pipe_room  = !(r_s1_v && r_s2_v && r_s3_v);
    assign o_status.recip_busy = recip_busy;
    assign o_valid             = r_s3_v;
    assign o_avg               = r_s3_avg;
    assign o_frame_end         = r_s3_fe;
endmodule

// File: sv/box_filter_image_downscaler_core.sv
// Box filter RGBA downscaler, top level: APB registers, pixel and result streams.
// Depends on bfds_pkg, bfds_if, bfds_ctrl and bfds_datapath.
//
// Source pixels stream in raster order at one pixel per clock while input is
// not held off; each completed factor-by-factor block yields one averaged RGBA
// pixel through a three-stage output pipeline (registers s1, s2, s3) that holds
// off input only once all three stages are full, which happens only while
// results are stalled on the output side. The average divides by factor
// squared through a multiply with a reciprocal, which a bit-serial unit
// computes after reset and after every register write, while input is held off.
// Per-column partial sums live in a MAX_DST_WIDTH-entry RAM that needs no
// clearing pass, since the first row of every block ignores and overwrites its entry.
// Registers: factor at 0x0, dst_width at 0x4, dst_height at 0x8; out-of-range
// values act as the nearest legal one, and a write to any of them restarts the frame.
module box_filter_image_downscaler_core #(
    parameter int MAX_DST_WIDTH = 256,
    parameter int MAX_FACTOR    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bfds_pix_if.sink                        i_pix,
    bfds_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bfds_pkg::ADDR_W-1:0]     paddr,
    input  logic [bfds_pkg::DATA_W-1:0]     pwdata,
    output logic [bfds_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import bfds_pkg::*;

    localparam int CW = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
    localparam int FW = $clog2(MAX_FACTOR + 1);

    t_dp_cmd     cmd;
    t_dp_status  status;
    logic [CW-1:0] col;
    logic [FW-1:0] factor;
    t_chan       pix [NUM_CH];
    t_chan       avg [NUM_CH];

    assign pready = 1'b1;

    assign pix[0] = i_pix.in_red;
    assign pix[1] = i_pix.in_green;
    assign pix[2] = i_pix.in_blue;
    assign pix[3] = i_pix.in_alpha;

    bfds_ctrl #(
        .MAX_DST_WIDTH (MAX_DST_WIDTH),
        .MAX_FACTOR    (MAX_FACTOR)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_col      (col),
        .o_factor   (factor)
    );

    bfds_datapath #(
        .MAX_DST_WIDTH (MAX_DST_WIDTH),
        .MAX_FACTOR    (MAX_FACTOR)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_col       (col),
        .i_factor    (factor),
        .i_pix       (pix),
        .o_status    (status),
        .o_valid     (o_res.valid),
        .i_ready     (o_res.ready),
        .o_avg       (avg),
        .o_frame_end (o_res.frame_end)
    );

    assign o_res.avg_red   = avg[0];
    assign o_res.avg_green = avg[1];
    assign o_res.avg_blue  = avg[2];
    assign o_res.avg_alpha = avg[3];
endmodule

// File: sv/bfds_checker.sv
// Port-level checker for the box filter downscaler, bound to the top level.
// Depends on bfds_pkg and box_filter_image_downscaler_core.
module bfds_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_ready,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  bfds_pkg::t_chan                 i_avg_red,
    input  bfds_pkg::t_chan                 i_avg_green,
    input  bfds_pkg::t_chan                 i_avg_blue,
    input  bfds_pkg::t_chan                 i_avg_alpha,
    input  logic                            i_frame_end,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [bfds_pkg::ADDR_W-1:0]     i_paddr
);
    import bfds_pkg::*;

    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 cfg_hit;

    assign cfg_idx = i_paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
    assign cfg_hit = i_psel && i_penable && i_pwrite
                     && (cfg_idx inside {REG_FACTOR, REG_WIDTH, REG_HEIGHT});

    // A register write restarts the reciprocal, so input must pause next cycle.
    a_cfg_holds_input: assert property (@(posedge i_clk)
        cfg_hit |=> !i_in_ready)
        else $error("input ready right after a register write");

    a_reset_flushes: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && !i_in_ready))
        else $error("result or ready right after reset");

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_avg_red) && $stable(i_avg_green) && $stable(i_avg_blue)
             && $stable(i_avg_alpha) && $stable(i_frame_end)))
        else $error("result beat changed while stalled");
endmodule

bind box_filter_image_downscaler_core bfds_checker u_bfds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_avg_red   (o_res.avg_red),
    .i_avg_green (o_res.avg_green),
    .i_avg_blue  (o_res.avg_blue),
    .i_avg_alpha (o_res.avg_alpha),
    .i_frame_end (o_res.frame_end),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr)
);
